// File: design/hdq_pkg.sv
// Package: shared types, constants and phase codes for the HDQ frame decoder.
`default_nettype none
package hdq_pkg;
	localparam int STAMP_BITS_DEF = 48;
	localparam int WIDTH_BITS_DEF = 24;
	localparam int CFG_IDX_BITS   = 3;
	localparam int NUM_CFG        = 6;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_MIN     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECOVERY_MIN  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIT_ONE_MAX   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_BIT_CYCLE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESPONSE_MIN  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESPONSE_MAX  = 3'd5;

	// reset values of the registers
	localparam int RST_BREAK_MIN     = 190;
	localparam int RST_RECOVERY_MIN  = 36;
	localparam int RST_BIT_ONE_MAX   = 50;
	localparam int RST_MIN_BIT_CYCLE = 190;
	localparam int RST_RESPONSE_MIN  = 190;
	localparam int RST_RESPONSE_MAX  = 950;

	// frame kinds
	localparam logic [2:0] KIND_BREAK      = 3'd0;
	localparam logic [2:0] KIND_RECOVERY   = 3'd1;
	localparam logic [2:0] KIND_ADDRESS    = 3'd2;
	localparam logic [2:0] KIND_READ_DATA  = 3'd3;
	localparam logic [2:0] KIND_WRITE_DATA = 3'd4;
	localparam logic [2:0] KIND_READ_FLAG  = 3'd5;
	localparam logic [2:0] KIND_WRITE_FLAG = 3'd6;

	localparam logic [7:0] ADDR_MASK = 8'h7F;

	typedef enum logic [3:0] {
		PH_WAIT_HIGH, PH_IDLE, PH_BREAK_LOW, PH_RECOVERY,
		PH_CMD_LOW, PH_CMD_HOLD, PH_CMD_FALL,
		PH_DATA_LOW, PH_DATA_HOLD, PH_DATA_FALL,
		PH_RESP_WAIT, PH_END_HOLD
	} phase_t;

	// edge event passed from the front end to the decoder
	typedef struct packed {
		logic lvl;
		logic fall;
		logic rise;
	} edge_info_t;
endpackage
`default_nettype wire

// File: design/hdq_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface hdq_stream_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/hdq_front.sv
// Front end: accepts line samples, stamps them and classifies edges.
`default_nettype none
module hdq_front #(
	parameter int STAMP_BITS = hdq_pkg::STAMP_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   line_valid,
	input  wire logic                   line_level,
	output logic                        line_ready,
	output logic                        q_valid,
	output hdq_pkg::edge_info_t         q_edge,
	output logic [STAMP_BITS-1:0]       q_now,
	input  wire logic                   q_ready
);
	import hdq_pkg::*;

	logic                  prev_q;
	logic [STAMP_BITS-1:0] count_q;
	logic                  valid_s1;
	edge_info_t            edge_s1;
	logic [STAMP_BITS-1:0] now_s1;
	logic                  take;

	// one-entry stage, refilled in the cycle it drains
	assign line_ready = !valid_s1 || q_ready;
	assign take       = line_valid && line_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (line_ready) valid_s1 <= line_valid;
			if (take) begin
				prev_q  <= line_level;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			edge_s1.lvl  <= line_level;
			edge_s1.fall <= prev_q && !line_level;
			edge_s1.rise <= !prev_q && line_level;
			now_s1       <= count_q;
		end
	end

	assign q_valid = valid_s1;
	assign q_edge  = edge_s1;
	assign q_now   = now_s1;
endmodule
`default_nettype wire

// File: design/hdq_back.sv
// Back end: HDQ phase machine and two-slot result queue.
`default_nettype none
module hdq_back #(
	parameter int STAMP_BITS = hdq_pkg::STAMP_BITS_DEF,
	parameter int WIDTH_BITS = hdq_pkg::WIDTH_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [hdq_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [WIDTH_BITS-1:0]        cfg_data,
	input  wire logic                         q_valid,
	input  wire hdq_pkg::edge_info_t          q_edge,
	input  wire logic [STAMP_BITS-1:0]        q_now,
	output logic                              q_ready,
	output logic                              o_valid,
	output logic [2:0]                        o_kind,
	output logic [7:0]                        o_value,
	output logic [7:0]                        o_cmd,
	output logic [STAMP_BITS-1:0]             o_start,
	output logic [STAMP_BITS-1:0]             o_end,
	output logic                              o_last,
	input  wire logic                         o_ready
);
	import hdq_pkg::*;

	typedef struct packed {
		logic [2:0]            kind;
		logic [7:0]            value;
		logic [7:0]            cmd;
		logic [STAMP_BITS-1:0] start;
		logic [STAMP_BITS-1:0] stop;
		logic                  last;
	} res_t;

	// configuration registers
	logic [WIDTH_BITS-1:0] break_min_q, recovery_min_q, bit_one_max_q;
	logic [WIDTH_BITS-1:0] min_bit_cycle_q, response_min_q, response_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_min_q     <= WIDTH_BITS'(RST_BREAK_MIN);
			recovery_min_q  <= WIDTH_BITS'(RST_RECOVERY_MIN);
			bit_one_max_q   <= WIDTH_BITS'(RST_BIT_ONE_MAX);
			min_bit_cycle_q <= WIDTH_BITS'(RST_MIN_BIT_CYCLE);
			response_min_q  <= WIDTH_BITS'(RST_RESPONSE_MIN);
			response_max_q  <= WIDTH_BITS'(RST_RESPONSE_MAX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BREAK_MIN:     break_min_q     <= cfg_data;
				REG_RECOVERY_MIN:  recovery_min_q  <= cfg_data;
				REG_BIT_ONE_MAX:   bit_one_max_q   <= cfg_data;
				REG_MIN_BIT_CYCLE: min_bit_cycle_q <= cfg_data;
				REG_RESPONSE_MIN:  response_min_q  <= cfg_data;
				REG_RESPONSE_MAX:  response_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decoder state
	phase_t                phase_q, phase_d;
	logic [STAMP_BITS-1:0] edge_q, edge_d, bstart_q, bstart_d, first_q, first_d;
	logic [STAMP_BITS-1:0] seventh_q, seventh_d, eighth_q, eighth_d;
	logic [7:0]            shift_q, shift_d, cmd_q, cmd_d;
	logic [2:0]            bidx_q, bidx_d;

	// result queue: two slots
	res_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;

	res_t       r0, r1;
	logic [1:0] n_res;
	logic       fire;
	logic       pop;
	logic [2:0] fill_next;

	// take the sample when the queue can hold its results after this cycle's pop
	assign pop       = o_valid && o_ready;
	assign fill_next = {1'b0, cnt_q} - {2'b00, pop} + {1'b0, n_res};
	assign q_ready   = fill_next <= 3'd2;
	assign fire      = q_valid && q_ready;

	// shared arithmetic for the current sample
	logic [STAMP_BITS-1:0] d_edge, pulse, bend, d8, hold8;
	logic                  short_cyc, is_one;
	logic [STAMP_BITS-1:0] fin_end;
	logic [7:0]            fin_byte;
	assign d_edge    = q_now - edge_q;
	assign pulse     = q_now - bstart_q;
	assign bend      = bstart_q + STAMP_BITS'(min_bit_cycle_q);
	assign short_cyc = pulse < STAMP_BITS'(min_bit_cycle_q);
	assign fin_end   = short_cyc ? bend : q_now;
	assign is_one    = pulse <= STAMP_BITS'(bit_one_max_q);
	assign fin_byte  = shift_q | (is_one ? (8'd1 << bidx_q) : 8'd0);
	assign d8        = q_now - eighth_q;
	assign hold8     = edge_q - eighth_q;

	// next-state logic
	always_comb begin
		logic       low_bit;
		phase_t     low_ph;
		phase_d   = phase_q;
		edge_d    = edge_q;
		bstart_d  = bstart_q;
		first_d   = first_q;
		seventh_d = seventh_q;
		eighth_d  = eighth_q;
		shift_d   = shift_q;
		cmd_d     = cmd_q;
		bidx_d    = bidx_q;
		low_bit   = 1'b0;
		low_ph    = PH_CMD_LOW;
		unique case (phase_q)
			PH_WAIT_HIGH: if (q_edge.lvl) phase_d = PH_IDLE;
			PH_IDLE: if (q_edge.fall) begin
				edge_d = q_now; phase_d = PH_BREAK_LOW;
			end
			PH_BREAK_LOW: if (q_edge.rise) begin
				if (d_edge >= STAMP_BITS'(break_min_q)) begin
					edge_d = q_now; phase_d = PH_RECOVERY;
				end else phase_d = PH_IDLE;
			end
			PH_RECOVERY: if (q_edge.fall) begin
				if (d_edge < STAMP_BITS'(recovery_min_q)) begin
					edge_d = q_now; phase_d = PH_BREAK_LOW;
				end else begin
					bidx_d = '0; low_bit = 1'b1; low_ph = PH_CMD_LOW;
				end
			end
			PH_CMD_LOW, PH_DATA_LOW: if (q_edge.rise) begin
				shift_d = fin_byte;
				edge_d  = fin_end;
				if (bidx_q == 3'd6) seventh_d = fin_end;
				bidx_d = bidx_q + 3'd1;
				if (phase_q == PH_CMD_LOW) begin
					if (bidx_q == 3'd7) begin
						cmd_d = fin_byte;
						if (fin_byte[7])
							phase_d = (fin_end == q_now) ? PH_DATA_FALL : PH_DATA_HOLD;
						else phase_d = PH_RESP_WAIT;
					end else
						phase_d = (fin_end == q_now) ? PH_CMD_FALL : PH_CMD_HOLD;
				end else begin
					if (bidx_q == 3'd7)
						phase_d = (fin_end == q_now) ? PH_IDLE : PH_END_HOLD;
					else
						phase_d = (fin_end == q_now) ? PH_DATA_FALL : PH_DATA_HOLD;
				end
			end
			PH_CMD_HOLD, PH_DATA_HOLD: if (q_now == edge_q) begin
				if (!q_edge.lvl) begin
					low_bit = 1'b1;
					low_ph  = (phase_q == PH_CMD_HOLD) ? PH_CMD_LOW : PH_DATA_LOW;
				end else
					phase_d = (phase_q == PH_CMD_HOLD) ? PH_CMD_FALL : PH_DATA_FALL;
			end
			PH_CMD_FALL: if (q_edge.fall) begin low_bit = 1'b1; low_ph = PH_CMD_LOW; end
			PH_DATA_FALL: if (q_edge.fall) begin low_bit = 1'b1; low_ph = PH_DATA_LOW; end
			PH_RESP_WAIT: if (q_edge.fall && d8 > hold8) begin
				if (d8 >= STAMP_BITS'(response_min_q) && d8 <= STAMP_BITS'(response_max_q)) begin
					bidx_d = '0; low_bit = 1'b1; low_ph = PH_DATA_LOW;
				end else if (d8 > STAMP_BITS'(response_max_q)) begin
					edge_d = q_now; phase_d = PH_BREAK_LOW;
				end
			end
			PH_END_HOLD: if (q_now == edge_q) begin
				if (!q_edge.lvl) begin edge_d = q_now; phase_d = PH_BREAK_LOW; end
				else phase_d = PH_IDLE;
			end
			default: phase_d = PH_WAIT_HIGH;
		endcase
		// start of a bit
		if (low_bit) begin
			bstart_d = q_now;
			if (bidx_d == 3'd0) begin first_d = q_now; shift_d = '0; end
			if (bidx_d == 3'd7) eighth_d = q_now;
			phase_d = low_ph;
		end
	end

	// result generation
	always_comb begin
		r0    = '0;
		r1    = '0;
		n_res = 2'd0;
		unique case (phase_q)
			PH_BREAK_LOW: if (q_edge.rise && d_edge >= STAMP_BITS'(break_min_q)) begin
				r0.kind = KIND_BREAK; r0.start = edge_q; r0.stop = q_now; n_res = 2'd1;
			end
			PH_RECOVERY: if (q_edge.fall && !(d_edge < STAMP_BITS'(recovery_min_q))) begin
				r0.kind = KIND_RECOVERY; r0.start = edge_q; r0.stop = q_now; n_res = 2'd1;
			end
			PH_CMD_LOW: if (q_edge.rise && bidx_q == 3'd7) begin
				r0.kind  = KIND_ADDRESS;
				r0.value = fin_byte & ADDR_MASK;
				r0.start = first_q;
				r0.stop  = seventh_q;
				r1.kind  = fin_byte[7] ? KIND_WRITE_FLAG : KIND_READ_FLAG;
				r1.value = {7'd0, fin_byte[7]};
				r1.start = eighth_q;
				r1.stop  = fin_end;
				n_res    = 2'd2;
			end
			PH_DATA_LOW: if (q_edge.rise && bidx_q == 3'd7) begin
				r0.kind  = cmd_q[7] ? KIND_WRITE_DATA : KIND_READ_DATA;
				r0.value = fin_byte;
				r0.cmd   = cmd_q;
				r0.start = first_q;
				r0.stop  = fin_end;
				n_res    = 2'd1;
			end
			default: ;
		endcase
		if (n_res == 2'd1) r0.last = 1'b1;
		if (n_res == 2'd2) r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_HIGH;
			edge_q <= '0; bstart_q <= '0; first_q <= '0;
			seventh_q <= '0; eighth_q <= '0;
			shift_q <= '0; cmd_q <= '0; bidx_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			edge_q <= edge_d; bstart_q <= bstart_d; first_q <= first_d;
			seventh_q <= seventh_d; eighth_q <= eighth_d;
			shift_q <= shift_d; cmd_q <= cmd_d; bidx_q <= bidx_d;
		end
	end

	// queue: rd_q points at the head slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			if (fire && n_res != 2'd0) begin
				cnt_q <= fill_next[1:0];
				rd_q  <= 1'b0;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
				rd_q  <= ~rd_q;
			end
		end
	end

	// on a write the surviving item (if any) is moved to slot 0
	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0) begin
			if ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2 && pop)) begin
				slot_q[0] <= slot_q[rd_q ^ pop];
				slot_q[1] <= r0;
			end else begin
				slot_q[0] <= r0;
				slot_q[1] <= r1;
			end
		end
	end

	res_t head;
	assign head    = slot_q[rd_q];
	assign o_valid = cnt_q != 2'd0;
	assign o_kind  = head.kind;
	assign o_value = head.value;
	assign o_cmd   = head.cmd;
	assign o_start = head.start;
	assign o_end   = head.stop;
	assign o_last  = head.last;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue overfilled");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n_res == 2'd2) |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
		else $error("two results taken without room");
	a_bidx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bidx_q == 3'd0))
		else $error("bit index not cleared when idle");
`endif
endmodule
`default_nettype wire

// File: design/hdq_bus_frame_decoder.sv
// Top level of the HDQ bus frame decoder.
`default_nettype none
// Decodes one HDQ line sample per item into break, recovery, address, flag and
// data frames stamped with sample indices. A front stage stamps each sample and
// marks edges; the decoder behind it takes one item per cycle while the queue
// has room and writes up to two result items into a two-slot queue. A result is
// offered in the cycle after the decoder takes its sample. Throughput is one
// sample per clock; the decoder takes a sample whenever the queue, after the
// head leaves in the same cycle, has room for that sample's results, so input
// stalls come only from results held back by the receiver.
module hdq_bus_frame_decoder #(
	parameter int STAMP_BITS = hdq_pkg::STAMP_BITS_DEF,
	parameter int WIDTH_BITS = hdq_pkg::WIDTH_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [hdq_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [WIDTH_BITS-1:0]            cfg_data,
	input  wire logic                             line_valid,
	output logic                                  line_ready,
	input  wire logic                             line_level,
	output logic                                  frame_valid,
	input  wire logic                             frame_ready,
	output logic [2:0]                            frame_kind,
	output logic [7:0]                            frame_value,
	output logic [7:0]                            command_byte,
	output logic [STAMP_BITS-1:0]                 start_sample,
	output logic [STAMP_BITS-1:0]                 end_sample,
	output logic                                  last_frame
);
	import hdq_pkg::*;

	logic                  q_valid, q_ready;
	edge_info_t            q_edge;
	logic [STAMP_BITS-1:0] q_now;

	hdq_front #(.STAMP_BITS(STAMP_BITS)) u_front (
		.clk, .arst_n, .line_valid, .line_level, .line_ready,
		.q_valid, .q_edge, .q_now, .q_ready
	);

	hdq_back #(.STAMP_BITS(STAMP_BITS), .WIDTH_BITS(WIDTH_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_edge, .q_now, .q_ready,
		.o_valid(frame_valid), .o_kind(frame_kind), .o_value(frame_value),
		.o_cmd(command_byte), .o_start(start_sample), .o_end(end_sample),
		.o_last(last_frame), .o_ready(frame_ready)
	);
endmodule
`default_nettype wire

// File: tb/sv/hdq_bus_frame_decoder_test.sv
// Testbench for the HDQ bus frame decoder: line waveforms in, checked frames out.
`timescale 1ns / 1ps

typedef struct packed {
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [7:0]  cmd;
	logic [47:0] first;
	logic [47:0] last_at;
	logic        last;
} frame_t;

// Scoreboard: decodes each accepted sample itself and holds the frames it owes
class frame_scoreboard;
	logic [23:0] regs [6];
	hdq_pkg::phase_t ph;
	bit prev;
	logic [47:0] cnt, edge_m, bit_st, first_st, seventh_end, eighth_st;
	logic [7:0] shift, held;
	logic [2:0] idx;
	frame_t frames_due [$];
	int errors;

	function new();
		regs[0] = 24'(hdq_pkg::RST_BREAK_MIN);
		regs[1] = 24'(hdq_pkg::RST_RECOVERY_MIN);
		regs[2] = 24'(hdq_pkg::RST_BIT_ONE_MAX);
		regs[3] = 24'(hdq_pkg::RST_MIN_BIT_CYCLE);
		regs[4] = 24'(hdq_pkg::RST_RESPONSE_MIN);
		regs[5] = 24'(hdq_pkg::RST_RESPONSE_MAX);
		ph = hdq_pkg::PH_WAIT_HIGH;
		prev = 1;
		cnt = 0; edge_m = 0; bit_st = 0; first_st = 0; seventh_end = 0; eighth_st = 0;
		shift = 0; held = 0; idx = 0; errors = 0;
	endfunction

	function void write_reg(int i, logic [23:0] v);
		regs[i] = v;
	endfunction

	function void owe(logic [2:0] k, logic [7:0] v, logic [7:0] c, logic [47:0] s,
			logic [47:0] e);
		frame_t f;
		f.kind = k; f.value = v; f.cmd = c; f.first = s; f.last_at = e; f.last = 0;
		frames_due.insert(frames_due.size(), f);
	endfunction

	function void start_bit(logic [47:0] now, hdq_pkg::phase_t low_ph);
		bit_st = now;
		if (idx == 0) begin
			first_st = now;
			shift = 0;
		end
		if (idx == 7)
			eighth_st = now;
		ph = low_ph;
	endfunction

	// close a bit at its rising edge; returns 1 when the byte is complete
	function bit close_bit(logic [47:0] now);
		logic [47:0] pulse, stop;
		pulse = now - bit_st;
		stop = now;
		if (pulse < {24'd0, regs[3]})
			stop = bit_st + {24'd0, regs[3]};
		if (pulse <= {24'd0, regs[2]})
			shift[idx] = 1'b1;
		if (idx == 6)
			seventh_end = stop;
		edge_m = stop;
		if (idx < 7) begin
			idx++;
			return 0;
		end
		idx = 0;
		return 1;
	endfunction

	function void decode_sample(bit lvl);
		logic [47:0] now, d, hold;
		bit fall, rise, is_cmd;
		int before_n;
		now = cnt;
		fall = prev && !lvl;
		rise = !prev && lvl;
		before_n = frames_due.size();
		case (ph)
			hdq_pkg::PH_WAIT_HIGH: if (lvl) ph = hdq_pkg::PH_IDLE;
			hdq_pkg::PH_IDLE: if (fall) begin
				edge_m = now;
				ph = hdq_pkg::PH_BREAK_LOW;
			end
			hdq_pkg::PH_BREAK_LOW: if (rise) begin
				if (now - edge_m >= {24'd0, regs[0]}) begin
					owe(hdq_pkg::KIND_BREAK, 0, 0, edge_m, now);
					edge_m = now;
					ph = hdq_pkg::PH_RECOVERY;
				end else
					ph = hdq_pkg::PH_IDLE;
			end
			hdq_pkg::PH_RECOVERY: if (fall) begin
				if (now - edge_m < {24'd0, regs[1]}) begin
					edge_m = now;
					ph = hdq_pkg::PH_BREAK_LOW;
				end else begin
					owe(hdq_pkg::KIND_RECOVERY, 0, 0, edge_m, now);
					idx = 0;
					start_bit(now, hdq_pkg::PH_CMD_LOW);
				end
			end
			hdq_pkg::PH_CMD_LOW: if (rise) begin
				if (close_bit(now)) begin
					held = shift;
					owe(hdq_pkg::KIND_ADDRESS, held & hdq_pkg::ADDR_MASK, 0, first_st,
						seventh_end);
					if (held[7]) begin
						owe(hdq_pkg::KIND_WRITE_FLAG, 1, 0, eighth_st, edge_m);
						ph = (edge_m == now) ? hdq_pkg::PH_DATA_FALL : hdq_pkg::PH_DATA_HOLD;
					end else begin
						owe(hdq_pkg::KIND_READ_FLAG, 0, 0, eighth_st, edge_m);
						ph = hdq_pkg::PH_RESP_WAIT;
					end
				end else
					ph = (edge_m == now) ? hdq_pkg::PH_CMD_FALL : hdq_pkg::PH_CMD_HOLD;
			end
			hdq_pkg::PH_DATA_LOW: if (rise) begin
				if (close_bit(now)) begin
					owe(held[7] ? hdq_pkg::KIND_WRITE_DATA : hdq_pkg::KIND_READ_DATA, shift,
						held, first_st, edge_m);
					ph = (edge_m == now) ? hdq_pkg::PH_IDLE : hdq_pkg::PH_END_HOLD;
				end else
					ph = (edge_m == now) ? hdq_pkg::PH_DATA_FALL : hdq_pkg::PH_DATA_HOLD;
			end
			hdq_pkg::PH_CMD_HOLD, hdq_pkg::PH_DATA_HOLD: if (now == edge_m) begin
				is_cmd = ph == hdq_pkg::PH_CMD_HOLD;
				if (!lvl)
					start_bit(now, is_cmd ? hdq_pkg::PH_CMD_LOW : hdq_pkg::PH_DATA_LOW);
				else
					ph = is_cmd ? hdq_pkg::PH_CMD_FALL : hdq_pkg::PH_DATA_FALL;
			end
			hdq_pkg::PH_CMD_FALL: if (fall) start_bit(now, hdq_pkg::PH_CMD_LOW);
			hdq_pkg::PH_DATA_FALL: if (fall) start_bit(now, hdq_pkg::PH_DATA_LOW);
			hdq_pkg::PH_RESP_WAIT: if (fall) begin
				d = now - eighth_st;
				hold = edge_m - eighth_st;
				if (d > hold) begin
					if (d >= {24'd0, regs[4]} && d <= {24'd0, regs[5]}) begin
						idx = 0;
						start_bit(now, hdq_pkg::PH_DATA_LOW);
					end else if (d > {24'd0, regs[5]}) begin
						edge_m = now;
						ph = hdq_pkg::PH_BREAK_LOW;
					end
				end
			end
			hdq_pkg::PH_END_HOLD: if (now == edge_m) begin
				if (!lvl) begin
					edge_m = now;
					ph = hdq_pkg::PH_BREAK_LOW;
				end else
					ph = hdq_pkg::PH_IDLE;
			end
			default: ph = hdq_pkg::PH_WAIT_HIGH;
		endcase
		if (frames_due.size() > before_n)
			frames_due[frames_due.size() - 1].last = 1;
		prev = lvl;
		cnt = cnt + 1;
	endfunction

	function void check_frame(frame_t got);
		frame_t want;
		if (frames_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected frame: %p", got);
			return;
		end
		want = frames_due.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("frame mismatch: expected %p, got %p", want, got);
		end
	endfunction
endclass

module hdq_bus_frame_decoder_test;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [hdq_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int tx_idle = 0, rx_idle = 0;
	int n_sent = 0;
	// local copies of the register values used to shape waveforms
	int bm, rm, b1, mbc, rmin, rmax;
	frame_scoreboard sb = new();

	hdq_stream_if #(.payload_t(logic)) line_ch (clk);
	hdq_stream_if #(.payload_t(frame_t)) frame_ch (clk);

	hdq_bus_frame_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.line_valid(line_ch.valid), .line_ready(line_ch.ready), .line_level(line_ch.data),
		.frame_valid(frame_ch.valid), .frame_ready(frame_ch.ready),
		.frame_kind(frame_ch.data.kind), .frame_value(frame_ch.data.value),
		.command_byte(frame_ch.data.cmd), .start_sample(frame_ch.data.first),
		.end_sample(frame_ch.data.last_at), .last_frame(frame_ch.data.last)
	);

	always #5 clk = ~clk;

	initial begin
		line_ch.valid = 0;
		line_ch.data = 1;
		frame_ch.ready = 0;
	end

	// receiver stalls
	always @(posedge clk) begin
		frame_ch.ready <= ($urandom % 100) >= rx_idle;
	end

	// accepted items on both sides
	always @(posedge clk) begin
		if (arst_n && line_ch.valid && line_ch.ready)
			sb.decode_sample(line_ch.data);
		if (arst_n && frame_ch.valid && frame_ch.ready)
			sb.check_frame(frame_ch.data);
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send_level(bit lvl);
		while (($urandom % 100) < tx_idle) begin
			line_ch.valid <= 0;
			@(posedge clk);
		end
		line_ch.valid <= 1;
		line_ch.data <= lvl;
		do @(posedge clk); while (!line_ch.ready);
		n_sent++;
	endtask

	task automatic send_run(bit lvl, int len);
		repeat (len) send_level(lvl);
	endtask

	// hold off until every owed frame is back, plus the decoder's latency
	task automatic drain();
		line_ch.valid <= 0;
		@(posedge clk);
		wait (sb.frames_due.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_regs(int v0, int v1, int v2, int v3, int v4, int v5);
		int vals [6];
		vals = '{v0, v1, v2, v3, v4, v5};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1;
			cfg_index <= i[hdq_pkg::CFG_IDX_BITS-1:0];
			cfg_data <= vals[i][23:0];
			@(posedge clk);
			sb.write_reg(i, vals[i][23:0]);
		end
		cfg_we <= 0;
		bm = v0; rm = v1; b1 = v2; mbc = v3; rmin = v4; rmax = v5;
	endtask

	// one bit slot: low pulse then high up to (or past) the minimum cycle
	task automatic send_bit(bit v, output int span);
		int w, h;
		w = v ? $urandom_range(1, b1) : $urandom_range(b1 + 1, b1 + 4);
		h = (mbc > w) ? mbc - w : 1;
		if ($urandom % 3 == 0)
			h += $urandom_range(1, 3);
		send_run(0, w);
		send_run(1, h);
		span = w + h;
	endtask

	task automatic send_byte(logic [7:0] b, output int last_span);
		for (int i = 0; i < 8; i++)
			send_bit(b[i], last_span);
	endtask

	// one transfer with random content, sometimes broken on purpose
	task automatic send_transfer();
		logic [7:0] cmd, dat;
		int span, d;
		if ($urandom % 8 == 0) begin
			repeat ($urandom_range(2, 8)) send_run($urandom % 2, $urandom_range(1, 4));
			return;
		end
		send_run(1, $urandom_range(1, 4));
		send_run(0, ($urandom % 6 == 0 && bm > 1) ? bm - 1 : bm + $urandom_range(0, 3));
		send_run(1, ($urandom % 6 == 0 && rm > 1) ? rm - 1 : rm + $urandom_range(0, 3));
		cmd = $urandom;
		dat = $urandom;
		if ($urandom % 6 == 0)
			cmd = ($urandom % 2) ? 8'hFF : 8'h00;
		send_byte(cmd, span);
		if (!cmd[7]) begin
			d = $urandom_range((rmin > 2) ? rmin - 2 : 0, rmax + 2);
			send_run(1, (d > span) ? d - span : 1);
		end
		if ($urandom % 10 != 0)
			send_byte(dat, span);
		send_run($urandom % 8 == 0 ? 0 : 1, $urandom_range(1, 5));
	endtask

	task automatic random_phase(int tx, int rx);
		int start_n;
		tx_idle = tx;
		rx_idle = rx;
		start_n = n_sent;
		while (n_sent - start_n < 380)
			send_transfer();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: low after reset, short lows at idle, reset register values
		send_run(0, 3);
		send_run(1, 3);
		send_run(0, 5);
		send_run(1, 2);
		send_run(0, 1);
		send_run(1, 3);

		// directed: a write at small settings, with extremes of the byte
		set_regs(6, 3, 3, 8, 4, 20);
		send_run(1, 2); send_run(0, 6); send_run(1, 3);
		begin
			int sp;
			send_byte(8'hFF, sp);
			send_byte(8'h00, sp);
		end

		random_phase(21, 64);
		set_regs(10, 5, 2, 6, 15, 10);
		random_phase(64, 21);
		// sender holds off until every owed frame is back
		drain();
		set_regs(5, 2, 4, 12, 12, 30);
		random_phase(0, 0);

		// register extremes with noise
		set_regs(0, 0, 0, 0, 0, 0);
		repeat (60) send_run($urandom % 2, $urandom_range(1, 3));
		set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		repeat (60) send_run($urandom % 2, $urandom_range(1, 3));
		set_regs(1, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
		repeat (60) send_run($urandom % 2, $urandom_range(1, 3));

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.frames_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
